/* sv/ripdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ripdc_pkg
// Shared constants, codes and types of the raw IPv4 discovery classifier.
// ----------------------------------------------------------------------------
package ripdc_pkg;

  localparam int MAX_PACKET_BYTES = 4096;
  localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int DISC_HDR_BYTES   = 12;

  localparam logic [7:0] DEFAULT_PROTOCOL = 8'd253;
  localparam logic [7:0] DEFAULT_OWN_ID   = 8'd1;

  localparam logic [7:0] TYPE_HELLO    = 8'h01;
  localparam logic [7:0] TYPE_QUERY    = 8'h02;
  localparam logic [7:0] TYPE_RESPONSE = 8'h03;

  localparam logic [3:0] MIN_IHL = 4'd5;

  localparam int PROTO_IDX     = 9;
  localparam int CHECK_LOW_IDX = 11;
  localparam int SRC_FIRST_IDX = 12;
  localparam int SRC_LAST_IDX  = 15;

  localparam logic [15:0] SUM_MASK = 16'hFFFF;

  localparam logic CFG_PROTOCOL_NUMBER = 1'b0;
  localparam logic CFG_OWN_ID          = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_HELLO          = 3'd0,
    VERDICT_QUERY          = 3'd1,
    VERDICT_RESPONSE       = 3'd2,
    VERDICT_UNKNOWN        = 3'd3,
    VERDICT_WRONG_PROTOCOL = 3'd4,
    VERDICT_TOO_SHORT      = 3'd5,
    VERDICT_BAD_CHECKSUM   = 3'd6,
    VERDICT_NOT_ADDRESSED  = 3'd7
  } verdict_t;

  typedef struct packed {
    logic [7:0]                          protocol;
    logic [3:0]                          header_words;
    logic [CNT_W-1:0]                    byte_count;
    logic [15:0]                         sum;
    logic [15:0]                         check;
    logic [31:0]                         source;
    logic [DISC_HDR_BYTES-1:0][7:0]      disc;
  } pkt_snap_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  message_type;
    logic [7:0]  origin_id;
    logic [31:0] exchange_id;
    logic [31:0] payload_length;
    logic [31:0] source_address;
    logic [6:0]  payload_offset;
  } result_t;

endpackage
`default_nettype wire

/* sv/ripdc_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ripdc_if
// Valid/ready channels for packet bytes and for classification results.
// ----------------------------------------------------------------------------
interface ripdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ripdc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [7:0]  message_type;
  logic [7:0]  origin_id;
  logic [31:0] exchange_id;
  logic [31:0] payload_length;
  logic [31:0] source_address;
  logic [6:0]  payload_offset;

  modport source (output valid, output verdict, output message_type, output origin_id,
                  output exchange_id, output payload_length, output source_address,
                  output payload_offset, input ready);
  modport sink   (input valid, input verdict, input message_type, input origin_id,
                  input exchange_id, input payload_length, input source_address,
                  input payload_offset, output ready);
endinterface
`default_nettype wire

/* sv/ripdc_parse.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ripdc_parse
// Per-packet byte capture: count, IHL, protocol, source, checksum sum and discovery header.
// ----------------------------------------------------------------------------
module ripdc_parse
  import ripdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  output pkt_snap_t       snap
);

  logic [CNT_W-1:0]               byte_count, byte_count_next;
  logic [3:0]                     header_words, header_words_next;
  logic [15:0]                    sum_accumulator, sum_accumulator_next;
  logic [7:0]                     pending_high_byte, pending_high_byte_next;
  logic [7:0]                     seen_protocol, seen_protocol_next;
  logic [31:0]                    captured_source, captured_source_next;
  logic [15:0]                    stored_check, stored_check_next;
  logic [DISC_HDR_BYTES-1:0][7:0] disc, disc_next;

  logic [CNT_W-1:0] hlen;
  logic [CNT_W-1:0] disc_k;
  logic [16:0]      sum_wide;
  logic             take;

  always_comb begin
    take                   = byte_count < CNT_W'(MAX_PACKET_BYTES);
    byte_count_next        = byte_count;
    header_words_next      = header_words;
    sum_accumulator_next   = sum_accumulator;
    pending_high_byte_next = pending_high_byte;
    seen_protocol_next     = seen_protocol;
    captured_source_next   = captured_source;
    stored_check_next      = stored_check;
    disc_next              = disc;

    if (take && byte_count == '0) begin
      header_words_next = data_byte[3:0];
    end
    hlen     = CNT_W'({header_words_next, 2'b00});
    disc_k   = byte_count - hlen;
    sum_wide = {1'b0, sum_accumulator} + {1'b0, pending_high_byte, data_byte};

    if (take) begin
      if (byte_count < hlen) begin
        if (!byte_count[0]) begin
          pending_high_byte_next = data_byte;
        end else if (byte_count == CNT_W'(CHECK_LOW_IDX)) begin
          stored_check_next = {pending_high_byte, data_byte};
        end else begin
          sum_accumulator_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
        end
      end
      if (byte_count == CNT_W'(PROTO_IDX)) begin
        seen_protocol_next = data_byte;
      end
      if (byte_count >= CNT_W'(SRC_FIRST_IDX) && byte_count <= CNT_W'(SRC_LAST_IDX)) begin
        captured_source_next = {captured_source[23:0], data_byte};
      end
      if (byte_count >= hlen && disc_k < CNT_W'(DISC_HDR_BYTES)) begin
        disc_next[disc_k[3:0]] = data_byte;
      end
      byte_count_next = byte_count + CNT_W'(1);
    end
  end

  assign snap = '{
    protocol:     seen_protocol_next,
    header_words: header_words_next,
    byte_count:   byte_count_next,
    sum:          sum_accumulator_next,
    check:        stored_check_next,
    source:       captured_source_next,
    disc:         disc_next
  };

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      byte_count        <= '0;
      header_words      <= '0;
      sum_accumulator   <= '0;
      pending_high_byte <= '0;
      seen_protocol     <= '0;
      captured_source   <= '0;
      stored_check      <= '0;
      disc              <= '0;
    end else if (step) begin
      byte_count        <= byte_count_next;
      header_words      <= header_words_next;
      sum_accumulator   <= sum_accumulator_next;
      pending_high_byte <= pending_high_byte_next;
      seen_protocol     <= seen_protocol_next;
      captured_source   <= captured_source_next;
      stored_check      <= stored_check_next;
      disc              <= disc_next;
    end
  end

endmodule
`default_nettype wire

/* sv/ripdc_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ripdc_classify
// Verdict and result fields from the captured state of a finished packet.
// ----------------------------------------------------------------------------
module ripdc_classify
  import ripdc_pkg::*;
(
  input  wire pkt_snap_t   snap,
  input  wire logic [7:0]  protocol_number,
  input  wire logic [7:0]  own_id,
  output result_t          result
);

  logic [6:0] need;
  logic [7:0] msg_type;
  logic [7:0] recv;

  always_comb begin
    need     = 7'({snap.header_words, 2'b00}) + 7'(DISC_HDR_BYTES);
    msg_type = snap.disc[0];
    recv     = snap.disc[DISC_HDR_BYTES-1];

    if (snap.protocol != protocol_number) begin
      result.verdict = VERDICT_WRONG_PROTOCOL;
    end else if (snap.header_words < MIN_IHL || snap.byte_count < CNT_W'(need)) begin
      result.verdict = VERDICT_TOO_SHORT;
    end else if ((~snap.sum & SUM_MASK) != snap.check) begin
      result.verdict = VERDICT_BAD_CHECKSUM;
    end else if (recv != 8'd0 && recv != own_id) begin
      result.verdict = VERDICT_NOT_ADDRESSED;
    end else begin
      case (msg_type)
        TYPE_HELLO:    result.verdict = VERDICT_HELLO;
        TYPE_QUERY:    result.verdict = VERDICT_QUERY;
        TYPE_RESPONSE: result.verdict = VERDICT_RESPONSE;
        default:       result.verdict = VERDICT_UNKNOWN;
      endcase
    end

    result.message_type   = msg_type;
    result.origin_id      = snap.disc[10];
    result.exchange_id    = {snap.disc[1], snap.disc[2], snap.disc[3], snap.disc[4]};
    result.payload_length = {snap.disc[5], snap.disc[6], snap.disc[7], snap.disc[8]};
    result.source_address = snap.source;
    result.payload_offset = need;
  end

endmodule
`default_nettype wire

/* sv/raw_ipv4_discovery_packet_classifier_core.sv */
`default_nettype none
// Result path: a last byte is held in the input register, then its result is registered.
// Throughput: one byte per cycle; the input register and result register decouple the
// channels, so bytes keep flowing while a result waits, up to one stalled last byte.
// Reset: synchronous; clears packet state and valids, loads protocol_number 253, own_id 1.
// ----------------------------------------------------------------------------
// raw_ipv4_discovery_packet_classifier_core
// Byte-serial IPv4 header check and discovery packet classification.
// ----------------------------------------------------------------------------
module raw_ipv4_discovery_packet_classifier_core
  import ripdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  ripdc_in_if.sink        packet,
  ripdc_out_if.source     result,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] protocol_number;
  logic [7:0] own_id;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;
  logic       out_free;

  pkt_snap_t  snap;
  result_t    res_comb;
  result_t    res;
  logic       res_valid;

  assign out_free     = !res_valid || result.ready;
  assign s1_adv       = !s1_last || out_free;
  assign packet.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_number <= DEFAULT_PROTOCOL;
      own_id          <= DEFAULT_OWN_ID;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PROTOCOL_NUMBER: protocol_number <= cfg_data;
        CFG_OWN_ID:          own_id          <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (packet.ready) begin
      s1_valid <= packet.valid;
    end
    if (packet.ready) begin
      s1_byte <= packet.data_byte;
      s1_last <= packet.last;
    end
  end

  ripdc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_valid && s1_adv),
    .data_byte (s1_byte),
    .last      (s1_last),
    .snap      (snap)
  );

  ripdc_classify u_classify (
    .snap            (snap),
    .protocol_number (protocol_number),
    .own_id          (own_id),
    .result          (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid && s1_last;
    end
    if (out_free && s1_valid && s1_last) begin
      res <= res_comb;
    end
  end

  assign result.valid          = res_valid;
  assign result.verdict        = res.verdict;
  assign result.message_type   = res.message_type;
  assign result.origin_id      = res.origin_id;
  assign result.exchange_id    = res.exchange_id;
  assign result.payload_length = res.payload_length;
  assign result.source_address = res.source_address;
  assign result.payload_offset = res.payload_offset;

endmodule
`default_nettype wire

/* sv/ripdc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ripdc_checker
// Port-level checks on the classifier result channel.
// ----------------------------------------------------------------------------
module ripdc_checker
  import ripdc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [2:0] verdict,
  input wire logic [7:0] message_type,
  input wire logic [6:0] payload_offset
);

  a_reset_clears_valid: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(verdict))
    else $error("stalled result request changed");

  a_header_length_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && (verdict == VERDICT_HELLO || verdict == VERDICT_QUERY ||
                  verdict == VERDICT_RESPONSE || verdict == VERDICT_UNKNOWN ||
                  verdict == VERDICT_BAD_CHECKSUM || verdict == VERDICT_NOT_ADDRESSED)
    |-> payload_offset >= 7'd32)
    else $error("accepted verdict with header below minimum length");

  a_type_matches: assert property (@(posedge clk) disable iff (rst)
    res_valid && (verdict == VERDICT_HELLO || verdict == VERDICT_QUERY ||
                  verdict == VERDICT_RESPONSE)
    |-> message_type == ({5'd0, verdict} + 8'd1))
    else $error("type verdict disagrees with message type");

endmodule

bind raw_ipv4_discovery_packet_classifier_core ripdc_checker u_ripdc_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .verdict        (result.verdict),
  .message_type   (result.message_type),
  .payload_offset (result.payload_offset)
);
`default_nettype wire
